/* sv/wlmg_pkg.sv */
// shared types, constants and helpers for the waypoint linear motion generator
package wlmg_pkg;

  localparam int QueueDepth = 16;
  localparam int CoordW     = 16;
  localparam int DiffW      = 17;
  localparam int PosW       = 33;
  localparam int StepW      = 18;
  localparam int CountW     = 17;
  localparam int OutW       = 24;
  localparam int DelayW     = 3;
  localparam int LenW       = 25;
  localparam int SumW       = 34;
  localparam int NumW       = 42;
  localparam int RemW       = 28;
  localparam int WordW      = 3 * CoordW;

  localparam logic [DelayW-1:0] SlowSpeed  = DelayW'(3);
  localparam logic [DelayW-1:0] FastSpeed  = DelayW'(1);
  localparam int                AccelTicks = 64;
  localparam int                DecelSteps = 128;

  typedef enum logic [2:0] {
    MODE_CONST_F     = 3'd0,
    MODE_ACCEL       = 3'd1,
    MODE_DECEL       = 3'd2,
    MODE_ACCEL_DECEL = 3'd3,
    MODE_CONST_S     = 3'd4
  } mode_e;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_NEXT = 1'b1
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_POINT,
    ST_SEG_RD,
    ST_SEG_P1,
    ST_SEG_P2,
    ST_SQUARE,
    ST_SQRT,
    ST_DIV_LOAD,
    ST_DIV_RUN,
    ST_SEG_DONE,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic                     operation;
    logic signed [CoordW-1:0] way_x;
    logic signed [CoordW-1:0] way_y;
    logic signed [CoordW-1:0] way_z;
  } req_t;

  typedef struct packed {
    logic                   point_valid;
    logic signed [OutW-1:0] point_x;
    logic signed [OutW-1:0] point_y;
    logic signed [OutW-1:0] point_z;
    logic [DelayW-1:0]      step_delay;
    logic                   more_points;
    logic                   push_dropped;
  } res_t;

  // q17.16 position to q16.8, floor and saturate
  function automatic logic signed [OutW-1:0] out_coord(input logic signed [PosW-1:0] p);
    logic signed [OutW:0] q;
    q = p[PosW-1:8];
    if (q[OutW] != q[OutW-1]) begin
      out_coord = q[OutW] ? {1'b1, {(OutW-1){1'b0}}} : {1'b0, {(OutW-1){1'b1}}};
    end else begin
      out_coord = q[OutW-1:0];
    end
  endfunction

endpackage

/* sv/wlmg_req_if.sv */
// request channel: valid, ready and one request payload
interface wlmg_req_if;
  logic            valid;
  logic            ready;
  wlmg_pkg::req_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* sv/wlmg_res_if.sv */
// result channel: valid, ready and one result payload
interface wlmg_res_if;
  logic            valid;
  logic            ready;
  wlmg_pkg::res_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* sv/wlmg_ram.sv */
// generic single-write, single-read ram with registered read data
module wlmg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

/* sv/waypoint_linear_motion_generator_top.sv */
// top level of the waypoint linear motion generator
// a segment start first runs 3 squares, 25 root steps and one divide per axis
// throughput: one request at a time; a new request is taken as soon as the previous result
//   sits in the output register, so the root and divide loop sets the rate
// reset: pointers, flags, counters and mode clear, the speed profile select comes up as 1
// the waypoint memory is not cleared; the ring pointers never read unwritten entries
module waypoint_linear_motion_generator_top #(
  parameter int QUEUE_DEPTH = wlmg_pkg::QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  wlmg_req_if.sink   req_i,
  wlmg_res_if.source res_o
);

  localparam int IdxW = $clog2(QUEUE_DEPTH);
  localparam int CW   = wlmg_pkg::CoordW;
  localparam int DW   = wlmg_pkg::DiffW;
  localparam int PW   = wlmg_pkg::PosW;
  localparam int SW   = wlmg_pkg::StepW;
  localparam int KW   = wlmg_pkg::CountW;
  localparam int LW   = wlmg_pkg::LenW;
  localparam int RW   = wlmg_pkg::RemW;
  localparam int NW   = wlmg_pkg::NumW;
  localparam int QW   = wlmg_pkg::DelayW;

  // ring successor, wraps at the configured depth
  function automatic logic [IdxW-1:0] ring_next(input logic [IdxW-1:0] i);
    ring_next = (i == IdxW'(QUEUE_DEPTH - 1)) ? '0 : i + IdxW'(1);
  endfunction

  wlmg_pkg::state_e state_q, state_d;

  // ring pointers and path flags
  logic [IdxW-1:0]   head_q, tail_q;
  logic              new_path_q;
  logic              var_speed_q;
  logic              after_first_q;   // segment start came from the new path check
  logic              seg_ok_q;
  wlmg_pkg::mode_e   mode_q;

  // motion state
  logic signed [PW-1:0] pos_q  [3];
  logic signed [SW-1:0] step_q [3];
  logic [KW-1:0]        steps_left_q;
  logic [KW-1:0]        tick_q;

  // segment setup datapath
  logic signed [CW-1:0] p1_q [3];
  logic signed [DW-1:0] d_q  [3];
  logic [wlmg_pkg::SumW-1:0] sum_q;
  logic [LW-1:0]        root_q;
  logic [RW-1:0]        rem_q;
  logic [4:0]           cnt_q;
  logic [1:0]           axis_q;
  logic [NW-1:0]        num_q;
  logic [SW-1:0]        quo_q;
  logic                 neg_q;

  // result staging and output register
  wlmg_pkg::res_t res_q;
  wlmg_pkg::res_t out_q;
  logic           out_valid_q;

  // memory port
  logic                       ram_wr_en, ram_rd_en;
  logic [wlmg_pkg::WordW-1:0] ram_wr_data, ram_rd_data;

  logic req_accept, is_push, ring_full, out_free;

  assign req_accept = req_i.valid && req_i.ready;
  assign is_push    = wlmg_pkg::op_e'(req_i.payload.operation) == wlmg_pkg::OP_PUSH;
  assign ring_full  = ring_next(head_q) == tail_q;
  assign out_free   = !out_valid_q || res_o.ready;

  assign ram_wr_data = {req_i.payload.way_z, req_i.payload.way_y, req_i.payload.way_x};

  wlmg_ram #(
    .WIDTH (wlmg_pkg::WordW),
    .DEPTH (QUEUE_DEPTH)
  ) u_way_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_wr_en),
    .wr_addr_i (head_q),
    .wr_data_i (ram_wr_data),
    .rd_en_i   (ram_rd_en),
    .rd_addr_i (tail_q),
    .rd_data_o (ram_rd_data)
  );

  // waypoint word split into axes
  logic signed [CW-1:0] rd_axis [3];
  assign rd_axis[0] = ram_rd_data[CW-1:0];
  assign rd_axis[1] = ram_rd_data[2*CW-1:CW];
  assign rd_axis[2] = ram_rd_data[3*CW-1:2*CW];

  // square of the current axis difference, one multiplier shared by the three axes
  logic signed [2*DW-1:0] sq_prod;
  assign sq_prod = d_q[axis_q] * d_q[axis_q];

  // square root: one result bit per cycle over the 50-bit radicand sum << 16
  logic [wlmg_pkg::SumW+15:0] rad;
  logic [1:0]    rad_pair;
  logic [RW-1:0] sq_rem_sh, sq_trial;
  logic          sq_take;
  assign rad       = {sum_q, 16'h0000};
  assign rad_pair  = rad[{cnt_q, 1'b0} +: 2];
  assign sq_rem_sh = {rem_q[RW-3:0], rad_pair};
  assign sq_trial  = {1'b0, root_q, 2'b01};
  assign sq_take   = sq_rem_sh >= sq_trial;

  // restoring divide by 2*length, 18 quotient bits
  logic [RW-1:0] dv_rem_sh, dv_div;
  logic          dv_take;
  assign dv_rem_sh = {rem_q[RW-2:0], num_q[6'(cnt_q)]};
  assign dv_div    = {2'b00, root_q, 1'b0};
  assign dv_take   = dv_rem_sh >= dv_div;

  // numerator of the current axis: |d| << 25 plus length for rounding
  logic [DW-1:0] d_mag;
  assign d_mag = d_q[axis_q][DW-1] ? DW'(-d_q[axis_q]) : DW'(d_q[axis_q]);

  // step count 1 + round(length)
  logic [LW:0]   len_rnd;
  logic [KW:0]   steps_new;
  assign len_rnd   = {1'b0, root_q} + (LW+1)'(128);
  assign steps_new = (KW+1)'(len_rnd[LW:8]) + (KW+1)'(1);

  // speed profile for the point being produced
  logic [KW-1:0] tick_n;
  logic          acc_mode, dec_mode;
  logic [QW-1:0] cv, delay;
  logic [6:0]    acc_left;
  logic [7:0]    dec_left;
  assign tick_n   = (tick_q != {KW{1'b1}}) ? tick_q + KW'(1) : tick_q;
  assign acc_mode = mode_q == wlmg_pkg::MODE_ACCEL || mode_q == wlmg_pkg::MODE_ACCEL_DECEL;
  assign dec_mode = mode_q == wlmg_pkg::MODE_DECEL || mode_q == wlmg_pkg::MODE_ACCEL_DECEL;
  assign cv       = (mode_q == wlmg_pkg::MODE_CONST_S) ? wlmg_pkg::SlowSpeed
                                                       : wlmg_pkg::FastSpeed;
  assign acc_left = 7'(wlmg_pkg::AccelTicks) - tick_n[6:0];
  assign dec_left = 8'(wlmg_pkg::DecelSteps) - steps_left_q[7:0];

  always_comb begin
    if (tick_n < KW'(wlmg_pkg::AccelTicks)) begin
      delay = acc_mode ? QW'(acc_left[5:4]) + QW'(1) : cv;
    end else if (steps_left_q < KW'(wlmg_pkg::DecelSteps)) begin
      delay = dec_mode ? QW'(dec_left[6:5]) + QW'(1) : cv;
    end else begin
      delay = cv;
    end
  end

  // mode picked at segment start; tail already points at the segment end
  wlmg_pkg::mode_e mode_new;
  logic            at_end;
  assign at_end = ring_next(tail_q) == head_q;
  always_comb begin
    if (!var_speed_q) begin
      mode_new = wlmg_pkg::MODE_CONST_S;
    end else if (at_end) begin
      mode_new = new_path_q ? wlmg_pkg::MODE_ACCEL_DECEL : wlmg_pkg::MODE_DECEL;
    end else begin
      mode_new = new_path_q ? wlmg_pkg::MODE_ACCEL : wlmg_pkg::MODE_CONST_F;
    end
  end

  // fresh result for an accepted request
  wlmg_pkg::res_t res_init;
  always_comb begin
    res_init              = '0;
    res_init.step_delay   = wlmg_pkg::FastSpeed;
    res_init.push_dropped = is_push && ring_full;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      wlmg_pkg::ST_IDLE: begin
        if (req_accept) begin
          if (is_push) begin
            state_d = wlmg_pkg::ST_EMIT;
          end else if (new_path_q) begin
            state_d = wlmg_pkg::ST_SEG_RD;
          end else begin
            state_d = wlmg_pkg::ST_POINT;
          end
        end
      end
      wlmg_pkg::ST_POINT: begin
        if (steps_left_q == KW'(0) || steps_left_q == KW'(1)) begin
          state_d = wlmg_pkg::ST_SEG_RD;
        end else begin
          state_d = wlmg_pkg::ST_EMIT;
        end
      end
      wlmg_pkg::ST_SEG_RD: begin
        state_d = (head_q == tail_q) ? wlmg_pkg::ST_SEG_DONE : wlmg_pkg::ST_SEG_P1;
      end
      wlmg_pkg::ST_SEG_P1: begin
        state_d = (head_q == tail_q) ? wlmg_pkg::ST_SEG_DONE : wlmg_pkg::ST_SEG_P2;
      end
      wlmg_pkg::ST_SEG_P2: state_d = wlmg_pkg::ST_SQUARE;
      wlmg_pkg::ST_SQUARE: begin
        if (axis_q == 2'd2) state_d = wlmg_pkg::ST_SQRT;
      end
      wlmg_pkg::ST_SQRT: begin
        if (cnt_q == 5'd0) state_d = wlmg_pkg::ST_DIV_LOAD;
      end
      wlmg_pkg::ST_DIV_LOAD: begin
        state_d = (root_q == '0) ? wlmg_pkg::ST_SEG_DONE : wlmg_pkg::ST_DIV_RUN;
      end
      wlmg_pkg::ST_DIV_RUN: begin
        if (cnt_q == 5'd0) begin
          state_d = (axis_q == 2'd2) ? wlmg_pkg::ST_SEG_DONE : wlmg_pkg::ST_DIV_LOAD;
        end
      end
      wlmg_pkg::ST_SEG_DONE: begin
        state_d = after_first_q ? wlmg_pkg::ST_POINT : wlmg_pkg::ST_EMIT;
      end
      wlmg_pkg::ST_EMIT: begin
        if (out_free) state_d = wlmg_pkg::ST_IDLE;
      end
      default: state_d = wlmg_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    req_i.ready = 1'b0;
    ram_wr_en   = 1'b0;
    ram_rd_en   = 1'b0;
    case (state_q)
      wlmg_pkg::ST_IDLE: begin
        req_i.ready = 1'b1;
        ram_wr_en   = req_accept && is_push && !ring_full;
      end
      wlmg_pkg::ST_SEG_RD, wlmg_pkg::ST_SEG_P1: begin
        ram_rd_en = head_q != tail_q;
      end
      default: begin
        ram_rd_en = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= wlmg_pkg::ST_IDLE;
      head_q        <= '0;
      tail_q        <= '0;
      new_path_q    <= 1'b0;
      var_speed_q   <= 1'b1;
      after_first_q <= 1'b0;
      seg_ok_q      <= 1'b0;
      mode_q        <= wlmg_pkg::MODE_CONST_F;
      steps_left_q  <= '0;
      tick_q        <= '0;
      out_valid_q   <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        pos_q[i]  <= '0;
        step_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) var_speed_q <= cfg_wdata_i;
      // in emit a taken result is replaced by the next one
      if (out_valid_q && res_o.ready && state_q != wlmg_pkg::ST_EMIT) out_valid_q <= 1'b0;
      case (state_q)
        wlmg_pkg::ST_IDLE: begin
          if (req_accept) begin
            if (is_push) begin
              if (!ring_full) begin
                head_q <= ring_next(head_q);
                if (head_q == tail_q) new_path_q <= 1'b1;
              end
            end else begin
              after_first_q <= new_path_q;
            end
          end
        end
        wlmg_pkg::ST_POINT: begin
          after_first_q <= 1'b0;
          if (steps_left_q != '0) begin
            tick_q       <= tick_n;
            steps_left_q <= steps_left_q - KW'(1);
            for (int i = 0; i < 3; i++) begin
              pos_q[i] <= pos_q[i] + PW'(step_q[i]);
            end
          end
        end
        wlmg_pkg::ST_SEG_RD: begin
          seg_ok_q <= 1'b0;
          if (head_q != tail_q) tail_q <= ring_next(tail_q);
        end
        wlmg_pkg::ST_SEG_P2: begin
          mode_q <= mode_new;
          for (int i = 0; i < 3; i++) begin
            pos_q[i] <= {p1_q[i][CW-1], p1_q[i], 16'h0000};
          end
        end
        wlmg_pkg::ST_DIV_LOAD: begin
          seg_ok_q <= 1'b1;
          if (axis_q == 2'd0) begin
            steps_left_q <= steps_new[KW-1:0];
            tick_q       <= '0;
          end
          if (root_q == '0) begin
            for (int i = 0; i < 3; i++) step_q[i] <= '0;
          end
        end
        wlmg_pkg::ST_DIV_RUN: begin
          if (cnt_q == 5'd0) begin
            step_q[axis_q] <= neg_q ? -$signed({quo_q[SW-2:0], dv_take})
                                    : $signed({quo_q[SW-2:0], dv_take});
          end
        end
        wlmg_pkg::ST_SEG_DONE: begin
          if (after_first_q) new_path_q <= 1'b0;
        end
        wlmg_pkg::ST_EMIT: begin
          if (out_free) out_valid_q <= 1'b1;
        end
        default: begin
          seg_ok_q <= seg_ok_q;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      wlmg_pkg::ST_IDLE: begin
        if (req_accept) res_q <= res_init;
      end
      wlmg_pkg::ST_POINT: begin
        if (steps_left_q != '0) begin
          res_q.point_valid <= 1'b1;
          res_q.point_x     <= wlmg_pkg::out_coord(pos_q[0]);
          res_q.point_y     <= wlmg_pkg::out_coord(pos_q[1]);
          res_q.point_z     <= wlmg_pkg::out_coord(pos_q[2]);
          res_q.step_delay  <= delay;
          res_q.more_points <= steps_left_q != KW'(1);
        end
      end
      wlmg_pkg::ST_SEG_P1: begin
        for (int i = 0; i < 3; i++) p1_q[i] <= rd_axis[i];
      end
      wlmg_pkg::ST_SEG_P2: begin
        for (int i = 0; i < 3; i++) begin
          d_q[i] <= {rd_axis[i][CW-1], rd_axis[i]} - {p1_q[i][CW-1], p1_q[i]};
        end
        sum_q  <= '0;
        axis_q <= 2'd0;
      end
      wlmg_pkg::ST_SQUARE: begin
        sum_q  <= sum_q + $unsigned(sq_prod);
        axis_q <= axis_q + 2'd1;
        root_q <= '0;
        rem_q  <= '0;
        cnt_q  <= 5'(LW - 1);
      end
      wlmg_pkg::ST_SQRT: begin
        if (sq_take) begin
          rem_q  <= sq_rem_sh - sq_trial;
          root_q <= {root_q[LW-2:0], 1'b1};
        end else begin
          rem_q  <= sq_rem_sh;
          root_q <= {root_q[LW-2:0], 1'b0};
        end
        cnt_q  <= cnt_q - 5'd1;
        axis_q <= 2'd0;
      end
      wlmg_pkg::ST_DIV_LOAD: begin
        num_q <= (NW'(d_mag) << 25) + NW'(root_q);
        // upper numerator bits above the 18 quotient positions
        rem_q <= RW'({d_mag, root_q[LW-1:SW]});
        neg_q <= d_q[axis_q][DW-1];
        quo_q <= '0;
        cnt_q <= 5'(SW - 1);
      end
      wlmg_pkg::ST_DIV_RUN: begin
        if (dv_take) begin
          rem_q <= dv_rem_sh - dv_div;
        end else begin
          rem_q <= dv_rem_sh;
        end
        quo_q <= {quo_q[SW-2:0], dv_take};
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd0) axis_q <= axis_q + 2'd1;
      end
      wlmg_pkg::ST_SEG_DONE: begin
        if (!after_first_q) res_q.more_points <= seg_ok_q;
      end
      wlmg_pkg::ST_EMIT: begin
        if (out_free) out_q <= res_q;
      end
      default: begin
        sum_q <= sum_q;
      end
    endcase
  end

  assign res_o.valid   = out_valid_q;
  assign res_o.payload = out_q;

`ifndef SYNTHESIS
  // the ring is never read at the free slot
  a_no_read_at_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_rd_en |-> tail_q != head_q)
    else $error("waypoint read at head");

  // a produced point carries a delay of 1 to 4
  a_delay_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.payload.point_valid |->
      res_o.payload.step_delay != 3'd0 && res_o.payload.step_delay <= 3'd4)
    else $error("step delay out of range");

  // a dropped push never comes with a point
  a_drop_no_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.payload.push_dropped |->
      !res_o.payload.point_valid && !res_o.payload.more_points)
    else $error("dropped push with point");

  // the ring write only happens for an accepted push with room
  a_write_on_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_wr_en |-> req_accept && !ring_full)
    else $error("ring write without room");
`endif

endmodule

/* verif/waypoint_linear_motion_generator_top_checker.sv */
// checker: watches request and result channels, predicts each result and compares
module waypoint_linear_motion_generator_top_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic           cfg_wdata_i,
  input  logic           req_valid_i,
  input  logic           req_ready_i,
  input  wlmg_pkg::req_t req_i,
  input  logic           res_valid_i,
  input  logic           res_ready_i,
  input  wlmg_pkg::res_t res_i,
  output int             fail_count_o,
  output int             pending_o
);

  localparam int Depth  = wlmg_pkg::QueueDepth;
  localparam int CoordW = wlmg_pkg::CoordW;
  localparam int PosW   = wlmg_pkg::PosW;
  localparam int StepW  = wlmg_pkg::StepW;
  localparam int CountW = wlmg_pkg::CountW;
  localparam int OutW   = wlmg_pkg::OutW;
  localparam int DelayW = wlmg_pkg::DelayW;

  logic signed [CoordW-1:0] ring_q [Depth][3];
  int unsigned head_q, tail_q;
  bit          fresh_path_q;
  logic signed [PosW-1:0]  pos_q [3];
  logic signed [StepW-1:0] step_q [3];
  logic [CountW-1:0] steps_left_q, ticks_q;
  wlmg_pkg::mode_e mode_q;
  bit              var_speed_q;
  wlmg_pkg::res_t  expected_points [$];

  assign pending_o = expected_points.size();

  function automatic int unsigned ring_inc(int unsigned i);
    return (i + 1 >= Depth) ? 0 : i + 1;
  endfunction

  function automatic longint unsigned root_of(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // floor to q16.8 and clamp
  function automatic logic signed [OutW-1:0] to_q8(logic signed [PosW-1:0] p);
    longint q;
    q = longint'(p) >>> 8;
    if (q > 8388607) q = 8388607;
    if (q < -8388608) q = -8388608;
    return q[OutW-1:0];
  endfunction

  function automatic bit begin_segment();
    longint a [3];
    longint d [3];
    longint unsigned s, lq, mag, q;
    bit last;
    s = 0;
    if (head_q == tail_q) return 0;
    for (int i = 0; i < 3; i++) a[i] = ring_q[tail_q][i];
    tail_q = ring_inc(tail_q);
    if (head_q == tail_q) return 0;
    last = ring_inc(tail_q) == head_q;
    if (!var_speed_q) mode_q = wlmg_pkg::MODE_CONST_S;
    else if (last) mode_q = fresh_path_q ? wlmg_pkg::MODE_ACCEL_DECEL : wlmg_pkg::MODE_DECEL;
    else mode_q = fresh_path_q ? wlmg_pkg::MODE_ACCEL : wlmg_pkg::MODE_CONST_F;
    for (int i = 0; i < 3; i++) begin
      d[i] = longint'(ring_q[tail_q][i]) - a[i];
      s += d[i] * d[i];
    end
    lq = root_of(s << 16);
    for (int i = 0; i < 3; i++) begin
      if (lq == 0) begin
        step_q[i] = '0;
      end else begin
        mag = d[i] < 0 ? -d[i] : d[i];
        q = ((mag << 25) + lq) / (2 * lq);
        step_q[i] = StepW'(d[i] < 0 ? -longint'(q) : longint'(q));
      end
      pos_q[i] = PosW'(a[i] * 65536);
    end
    steps_left_q = CountW'(1 + ((lq + 128) >> 8));
    ticks_q = '0;
    return 1;
  endfunction

  function automatic wlmg_pkg::res_t predict_point(wlmg_pkg::req_t r);
    wlmg_pkg::res_t o;
    logic [DelayW-1:0] cv, dl;
    bit acc, dec;
    o = '0;
    o.step_delay = wlmg_pkg::FastSpeed;
    if (wlmg_pkg::op_e'(r.operation) == wlmg_pkg::OP_PUSH) begin
      if (ring_inc(head_q) == tail_q) begin
        o.push_dropped = 1'b1;
        return o;
      end
      ring_q[head_q][0] = r.way_x;
      ring_q[head_q][1] = r.way_y;
      ring_q[head_q][2] = r.way_z;
      if (head_q == tail_q) fresh_path_q = 1;
      head_q = ring_inc(head_q);
      return o;
    end
    if (fresh_path_q) begin
      void'(begin_segment());
      fresh_path_q = 0;
    end
    if (steps_left_q != 0) begin
      cv = (mode_q == wlmg_pkg::MODE_CONST_S) ? wlmg_pkg::SlowSpeed : wlmg_pkg::FastSpeed;
      acc = mode_q inside {wlmg_pkg::MODE_ACCEL, wlmg_pkg::MODE_ACCEL_DECEL};
      dec = mode_q inside {wlmg_pkg::MODE_DECEL, wlmg_pkg::MODE_ACCEL_DECEL};
      if (ticks_q != '1) ticks_q++;
      if (ticks_q < wlmg_pkg::AccelTicks) begin
        dl = acc ? DelayW'((wlmg_pkg::AccelTicks - int'(ticks_q)) / 16 + 1) : cv;
      end else if (steps_left_q < wlmg_pkg::DecelSteps) begin
        dl = dec ? DelayW'((wlmg_pkg::DecelSteps - int'(steps_left_q)) / 32 + 1) : cv;
      end else begin
        dl = cv;
      end
      o.point_valid = 1'b1;
      o.point_x = to_q8(pos_q[0]);
      o.point_y = to_q8(pos_q[1]);
      o.point_z = to_q8(pos_q[2]);
      for (int i = 0; i < 3; i++) pos_q[i] = pos_q[i] + PosW'(step_q[i]);
      o.step_delay = dl;
      steps_left_q--;
      o.more_points = steps_left_q != 0 ? 1'b1 : begin_segment();
    end else begin
      o.more_points = begin_segment();
    end
    return o;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d, expected %0d", what, got, want);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    wlmg_pkg::res_t want;
    if (!rst_ni) begin
      head_q = 0;
      tail_q = 0;
      fresh_path_q = 0;
      for (int i = 0; i < 3; i++) begin
        pos_q[i] = '0;
        step_q[i] = '0;
      end
      steps_left_q = '0;
      ticks_q = '0;
      mode_q = wlmg_pkg::MODE_CONST_F;
      var_speed_q = 1;
      expected_points.delete();
      fail_count_o = 0;
    end else begin
      if (res_valid_i && res_ready_i) begin
        if (expected_points.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          want = expected_points.pop_front();
          if (res_i.point_valid !== want.point_valid)
            report_mismatch("point_valid", res_i.point_valid, want.point_valid);
          if (res_i.point_x !== want.point_x)
            report_mismatch("point_x", res_i.point_x, want.point_x);
          if (res_i.point_y !== want.point_y)
            report_mismatch("point_y", res_i.point_y, want.point_y);
          if (res_i.point_z !== want.point_z)
            report_mismatch("point_z", res_i.point_z, want.point_z);
          if (res_i.step_delay !== want.step_delay)
            report_mismatch("step_delay", res_i.step_delay, want.step_delay);
          if (res_i.more_points !== want.more_points)
            report_mismatch("more_points", res_i.more_points, want.more_points);
          if (res_i.push_dropped !== want.push_dropped)
            report_mismatch("push_dropped", res_i.push_dropped, want.push_dropped);
        end
      end
      if (cfg_we_i) var_speed_q = cfg_wdata_i;
      if (req_valid_i && req_ready_i) expected_points.push_back(predict_point(req_i));
    end
  end

endmodule

/* verif/waypoint_linear_motion_generator_top_tb.sv */
// testbench top: clock, reset, request stimulus, result stalls and verdict
module waypoint_linear_motion_generator_top_tb;

  localparam int StallLimit = 20000;
  localparam int CoordW     = wlmg_pkg::CoordW;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_wdata_i = 1'b0;
  int   fail_count, pending;
  int   idle_cycles = 0;

  wlmg_req_if req_if ();
  wlmg_res_if res_if ();

  always #5 clk_i = ~clk_i;

  waypoint_linear_motion_generator_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_if),
    .res_o       (res_if)
  );

  waypoint_linear_motion_generator_top_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .req_valid_i  (req_if.valid),
    .req_ready_i  (req_if.ready),
    .req_i        (req_if.payload),
    .res_valid_i  (res_if.valid),
    .res_ready_i  (res_if.ready),
    .res_i        (res_if.payload),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // result side stalls on its own pattern: quiet stretches, then random back-pressure
  initial begin
    int phase;
    phase = 0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      phase++;
      if ((phase / 300) % 3 == 0) res_if.ready <= 1'b1;
      else res_if.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // watchdog: cycles with no request or result accepted
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > StallLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // burst bookkeeping for the sender
  int burst_left = 0;

  // send one request; gaps between bursts, valid stays up inside a burst
  task automatic send_request(wlmg_pkg::op_e op, logic signed [CoordW-1:0] x,
                              logic signed [CoordW-1:0] y, logic signed [CoordW-1:0] z);
    wlmg_pkg::req_t r;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(0, 1) ? $urandom_range(1, 6) : 0;
      if (gap != 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    r.operation = op;
    r.way_x = x;
    r.way_y = y;
    r.way_z = z;
    req_if.payload <= r;
    req_if.valid <= 1'b1;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic push_point(int x, int y, int z);
    send_request(wlmg_pkg::OP_PUSH, CoordW'(x), CoordW'(y), CoordW'(z));
  endtask

  task automatic next_point();
    send_request(wlmg_pkg::OP_NEXT, CoordW'($urandom), CoordW'($urandom), CoordW'($urandom));
  endtask

  // stop sending, wait until every result is in, then let the block settle
  task automatic drain_results();
    req_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (120) @(negedge clk_i);
  endtask

  task automatic write_speed_mode(bit v);
    drain_results();
    cfg_wdata_i <= v;
    cfg_we_i <= 1'b1;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // short random coordinate, occasionally a full-range one
  function automatic int pick_coord();
    if ($urandom_range(0, 9) == 0) return $signed(16'($urandom));
    return $urandom_range(0, 60) - 30;
  endfunction

  initial begin
    int sent, kind;
    req_if.valid = 1'b0;
    req_if.payload = '0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // request with nothing queued, then extremes and a zero-length segment
    next_point();
    push_point(-32768, 32767, -32768);
    push_point(32767, -32768, 32767);
    next_point();
    next_point();
    push_point(5, 5, 5);
    push_point(5, 5, 5);
    repeat (4) next_point();
    // fill the ring past full so pushes get dropped
    for (int i = 0; i < 17; i++) push_point(i, -i, 2 * i);
    write_speed_mode(1'b0);
    repeat (3) next_point();
    write_speed_mode(1'b1);

    sent = 0;
    while (sent < 800) begin
      if (sent == 400) begin
        write_speed_mode(1'b0);
      end else if (sent == 600) begin
        write_speed_mode(1'b1);
      end
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        push_point(pick_coord(), pick_coord(), pick_coord());
      end else begin
        next_point();
      end
      if (sent == 250) drain_results();
      sent++;
    end
    // a few more point requests to walk along what is still queued
    repeat (200) next_point();

    drain_results();
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
